// ===== design/adcps_pkg.sv =====
//------------------------------------------------------------------------------
// adcps_pkg: shared types and constants for the ADC priority sequencer filter
// Holds sizes, order codes, request function codes and the command-word helper.
//------------------------------------------------------------------------------
`default_nettype none

package adcps_pkg;

    localparam int Channels   = 8;
    localparam int Window     = 16;
    localparam int OrderDepth = 22;

    localparam int ChW   = $clog2(Channels);
    localparam int WinW  = $clog2(Window);
    localparam int OrdW  = $clog2(OrderDepth);
    localparam int LenW  = $clog2(OrderDepth + 1);
    localparam int SumW  = 16 + WinW;
    localparam int AddrW = ChW + WinW;

    localparam logic [3:0]  OrderEnd   = 4'd15;
    localparam logic [3:0]  TempSelect = 4'd8;
    localparam logic [15:0] CfrDefault = 16'h2041;

    typedef enum logic [1:0] {
        FUNC_CONV    = 2'd0,
        FUNC_PRIO    = 2'd1,
        FUNC_RESTORE = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_COUNT = 2'd0,
        REG_TWO   = 2'd1,
        REG_REMAP = 2'd2,
        REG_NONE  = 2'd3
    } t_reg;

    // Front-to-back request for one conversion sample.
    typedef struct packed {
        logic [ChW-1:0] chan;
        logic [15:0]    sample;
    } t_store_req;

    function automatic logic [15:0] select_word(input logic [3:0] sel,
                                                input logic remap);
        logic [2:0] inp;
        begin
            inp = sel[2:0];
            if (remap && sel < 4'd4) begin
                unique case (sel[1:0])
                    2'd0: inp = 3'd0;
                    2'd1: inp = 3'd2;
                    2'd2: inp = 3'd5;
                    default: inp = 3'd7;
                endcase
            end
            if (sel >= TempSelect)
                select_word = 16'((16'((3 << 10)) + CfrDefault) << 2);
            else
                select_word = 16'((16'(7 << 10) + {6'd0, inp, 7'd0} + CfrDefault) << 2);
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/adcps_ram.sv =====
//------------------------------------------------------------------------------
// adcps_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module adcps_ram #(
    parameter int Width = 16,
    parameter int Depth = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/adcps_filter.sv =====
//------------------------------------------------------------------------------
// adcps_filter: back part, per-channel 16-sample window average
// Reads the oldest sample of the channel ring, replaces it and updates the sum.
// The sample store is cleared by a sweep after reset.
//------------------------------------------------------------------------------
`default_nettype none

module adcps_filter
    import adcps_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    input  wire t_store_req i_req,
    output logic            o_req_ready,
    output logic            o_clear_busy,
    output logic            o_done,
    output logic [ChW-1:0]  o_chan,
    output logic [15:0]     o_avg
);

    typedef enum logic [1:0] {
        F_CLEAR, F_IDLE, F_READ, F_WRITE
    } t_fstate;

    t_fstate r_state, n_state;
    logic [AddrW:0]    r_clr;
    logic [WinW-1:0]   r_ring [Channels];
    logic [SumW-1:0]   r_sum  [Channels];
    t_store_req        r_req;
    logic [15:0]       w_old;
    logic              w_we;
    logic [AddrW-1:0]  w_waddr, w_raddr;
    logic [15:0]       w_wdata;
    logic [SumW-1:0]   w_newsum;

    assign w_raddr  = {r_req.chan, r_ring[r_req.chan]};
    assign w_newsum = r_sum[r_req.chan] - SumW'(w_old) + SumW'(r_req.sample);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_CLEAR: if (r_clr == (AddrW+1)'(Channels*Window - 1)) n_state = F_IDLE;
            F_IDLE:  if (i_req_valid) n_state = F_READ;
            F_READ:  n_state = F_WRITE;
            F_WRITE: n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready  = (r_state == F_IDLE);
        o_clear_busy = (r_state == F_CLEAR);
        w_we    = 1'b0;
        w_waddr = w_raddr;
        w_wdata = r_req.sample;
        unique case (r_state)
            F_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr[AddrW-1:0];
                w_wdata = '0;
            end
            F_WRITE: w_we = 1'b1;
            default: ;
        endcase
    end

    adcps_ram #(.Width(16), .Depth(Channels*Window)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_old)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_CLEAR;
            r_clr   <= '0;
            o_done  <= 1'b0;
            for (int c = 0; c < Channels; c++) begin
                r_ring[c] <= '0;
                r_sum[c]  <= '0;
            end
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            if (r_state == F_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == F_WRITE) begin
                r_sum[r_req.chan]  <= w_newsum;
                r_ring[r_req.chan] <= r_ring[r_req.chan] + 1'b1;
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        if (r_state == F_WRITE) begin
            o_chan <= r_req.chan;
            o_avg  <= w_newsum[SumW-1:WinW];
        end
    end

    a_done_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == F_WRITE |=> o_done)
        else $error("average not reported after write");
    a_read_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == F_READ |=> r_state == F_WRITE)
        else $error("read not followed by write");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clear_busy |-> !o_req_ready)
        else $error("ready during clear");

endmodule

`default_nettype wire

// ===== design/adcps_queue.sv =====
//------------------------------------------------------------------------------
// adcps_queue: two-entry queue between sequencer and filter
// Carries sample store requests so the front can move on independently.
//------------------------------------------------------------------------------
`default_nettype none

module adcps_queue
    import adcps_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_store_req i_data,
    output logic            o_full,
    output logic            o_valid,
    input  wire logic       i_pop,
    output t_store_req      o_data
);

    t_store_req r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (i_push && !o_full) r_wr <= ~r_wr;
            if (i_pop && o_valid)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'((i_push && !o_full)) - 2'((i_pop && o_valid));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_q[r_wr] <= i_data;
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== design/adcps_seq.sv =====
//------------------------------------------------------------------------------
// adcps_seq: front part, conversion order sequencer
// Holds current and pending orders, walks them for swaps and priority rebuilds,
// and issues sample store requests for conversions.
//------------------------------------------------------------------------------
`default_nettype none

module adcps_seq
    import adcps_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [1:0]     i_func,
    input  wire logic [15:0]    i_sample,
    input  wire logic [2:0]     i_request_channel,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [3:0]     i_cfg_data,
    input  wire logic           i_q_full,
    input  wire logic           i_hold,
    output logic                o_busy,
    output logic                o_push,
    output t_store_req          o_push_data,
    output logic                o_expect_avg,
    output logic                o_res,
    output logic [3:0]          o_next_select,
    output logic                o_remap,
    output logic                o_request_ok
);

    typedef enum logic [2:0] {
        S_IDLE, S_PUSH, S_BUILD, S_COPY, S_RESULT
    } t_sstate;

    t_sstate r_state, n_state;
    logic [3:0]      r_cur  [OrderDepth];
    logic [3:0]      r_pend [OrderDepth];
    logic [OrdW-1:0] r_pos;
    logic [LenW-1:0] r_len;
    logic            r_swap, r_fresh;
    logic [3:0]      r_count;
    logic            r_two, r_remap;
    logic [3:0]      r_next;
    logic            r_ok, r_exp;
    // Walker state for the priority rebuild and the order copy.
    logic [3:0]      r_i;
    logic [LenW-1:0] r_j;
    logic [2:0]      r_chan;
    logic [3:0]      r_p;
    logic [1:0]      r_k;
    logic            r_found;
    logic            r_sel_pend;
    logic            r_do_store;
    t_store_req      r_sreq;

    logic [3:0]      w_used;
    logic [4:0]      w_pos1;
    logic            w_wrap;
    logic [OrdW-1:0] w_didx;
    logic [5:0]      w_t;
    logic [3:0]      w_put;
    logic            w_skip;

    assign w_used = (r_count == 4'd0 || r_count > 4'(Channels)) ? 4'(Channels) : r_count;
    assign w_pos1 = 5'(r_pos) + 5'd1;
    assign w_wrap = (w_pos1 >= 5'(r_len)) || (w_pos1 >= 5'(OrderDepth));

    // Index of the entry two positions back, modulo the current order length.
    always_comb begin
        if (r_pos >= OrdW'(2)) begin
            w_t = 6'(r_pos) - 6'd2;
        end else begin
            w_t = 6'(r_len) + 6'(r_pos) - 6'd2;
        end
        if (w_t >= 6'(OrderDepth)) w_t = w_t - 6'(OrderDepth);
        w_didx = OrdW'(w_t);
    end

    // Entry placed at this walker step: chan, then the partner, then i.
    always_comb begin
        w_skip = (r_i == {1'b0, r_chan}) || (r_two && r_i == r_p);
        if (r_k == 2'd0)      w_put = {1'b0, r_chan};
        else if (r_k == 2'd1 && r_two) w_put = r_p;
        else                  w_put = r_i;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && !i_hold) begin
                    priority case (t_func'(i_func))
                        FUNC_CONV:  n_state = S_PUSH;
                        FUNC_PRIO:  n_state = ({1'b0, i_request_channel} < w_used) ?
                                              S_BUILD : S_RESULT;
                        default:    n_state = S_RESULT;
                    endcase
                end
            end
            S_PUSH: begin
                if (!(r_do_store && i_q_full)) n_state = r_sel_pend ? S_COPY : S_RESULT;
            end
            S_BUILD: begin
                if (r_i >= w_used && r_j >= LenW'(OrderDepth)) n_state = S_RESULT;
            end
            S_COPY: begin
                if (r_j >= LenW'(OrderDepth)) n_state = S_RESULT;
            end
            S_RESULT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = (r_state != S_IDLE) || i_hold;
        o_push        = (r_state == S_PUSH) && r_do_store && !i_q_full;
        o_push_data   = r_sreq;
        o_res         = (r_state == S_RESULT);
        o_next_select = r_next;
        o_remap       = r_remap;
        o_request_ok  = r_ok;
        o_expect_avg  = r_exp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= 4'd8;
            r_two   <= 1'b0;
            r_remap <= 1'b0;
            r_pos   <= '0;
            r_len   <= LenW'(8);
            r_swap  <= 1'b0;
            r_fresh <= 1'b0;
            r_next  <= TempSelect;
            r_ok    <= 1'b0;
            r_exp   <= 1'b0;
            r_do_store <= 1'b0;
            r_sel_pend <= 1'b0;
            for (int e = 0; e < OrderDepth; e++) begin
                r_cur[e]  <= (e < 8) ? 4'(e) : OrderEnd;
                r_pend[e] <= (e < 8) ? 4'(e) : OrderEnd;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_index))
                    REG_COUNT: begin
                        r_count <= i_cfg_data;
                        r_pos   <= '0;
                        r_swap  <= 1'b0;
                        r_fresh <= 1'b0;
                        r_len   <= LenW'((i_cfg_data == 4'd0 || i_cfg_data > 4'(Channels)) ?
                                         4'(Channels) : i_cfg_data);
                        for (int e = 0; e < OrderDepth; e++) begin
                            r_cur[e]  <= (4'(e) < ((i_cfg_data == 4'd0 ||
                                         i_cfg_data > 4'(Channels)) ? 4'(Channels) :
                                         i_cfg_data)) ? 4'(e) : OrderEnd;
                            r_pend[e] <= (4'(e) < ((i_cfg_data == 4'd0 ||
                                         i_cfg_data > 4'(Channels)) ? 4'(Channels) :
                                         i_cfg_data)) ? 4'(e) : OrderEnd;
                        end
                    end
                    REG_TWO:   r_two   <= i_cfg_data[0];
                    REG_REMAP: r_remap <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && !i_hold) begin
                        r_ok  <= 1'b0;
                        r_exp <= 1'b0;
                        unique case (t_func'(i_func))
                            FUNC_CONV: begin
                                r_sreq.sample <= i_sample;
                                r_do_store    <= 1'b0;
                                r_sel_pend    <= 1'b0;
                                if (r_len >= LenW'(2) && (r_pos >= OrdW'(2) || !r_fresh)) begin
                                    r_sreq.chan <= r_cur[w_didx][ChW-1:0];
                                    r_do_store  <= (r_cur[w_didx] < 4'(Channels));
                                    r_exp       <= (r_cur[w_didx] < 4'(Channels));
                                end
                                if (r_len >= LenW'(2) && r_pos >= OrdW'(2)) r_fresh <= 1'b0;
                                if (w_wrap) begin
                                    r_pos <= '0;
                                    if (r_swap) begin
                                        r_fresh    <= 1'b1;
                                        r_swap     <= 1'b0;
                                        r_sel_pend <= 1'b1;
                                        r_j        <= '0;
                                        r_found    <= 1'b0;
                                        r_len      <= LenW'(OrderDepth);
                                        r_next     <= r_pend[0];
                                    end else begin
                                        r_next <= r_cur[0];
                                    end
                                end else begin
                                    r_pos  <= OrdW'(w_pos1);
                                    r_next <= r_cur[OrdW'(w_pos1)];
                                end
                            end
                            FUNC_PRIO: begin
                                if ({1'b0, i_request_channel} < w_used) begin
                                    r_ok   <= 1'b1;
                                    r_swap <= 1'b1;
                                    r_chan <= i_request_channel;
                                    r_p    <= r_pend[0];
                                    r_i    <= '0;
                                    r_j    <= '0;
                                    r_k    <= '0;
                                end
                            end
                            FUNC_RESTORE: begin
                                r_ok   <= 1'b1;
                                r_swap <= 1'b1;
                                for (int e = 0; e < OrderDepth; e++) begin
                                    r_pend[e] <= (4'(e) < w_used) ? 4'(e) : OrderEnd;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_BUILD: begin
                    // One order entry per cycle, except that a step that skips a channel writes none.
                    if (r_i < w_used) begin
                        if (w_skip) begin
                            r_i <= r_i + 4'd1;
                        end else begin
                            if (r_j < LenW'(OrderDepth)) begin
                                r_pend[OrdW'(r_j)] <= w_put;
                                r_j <= r_j + 1'b1;
                            end
                            if ((r_two && r_k == 2'd2) || (!r_two && r_k == 2'd1)) begin
                                r_k <= '0;
                                r_i <= r_i + 4'd1;
                            end else begin
                                r_k <= r_k + 2'd1;
                            end
                        end
                    end else if (r_j < LenW'(OrderDepth)) begin
                        r_pend[OrdW'(r_j)] <= OrderEnd;
                        r_j <= r_j + 1'b1;
                    end
                end
                S_COPY: begin
                    if (r_j < LenW'(OrderDepth)) begin
                        r_cur[OrdW'(r_j)] <= r_pend[OrdW'(r_j)];
                        if (!r_found && r_pend[OrdW'(r_j)] == OrderEnd) begin
                            r_found <= 1'b1;
                            r_len   <= r_j;
                        end
                        r_j <= r_j + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    a_ok_only_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BUILD |-> r_swap)
        else $error("rebuild without pending swap");
    a_res_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RESULT |=> r_state == S_IDLE)
        else $error("result state held");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < OrdW'(OrderDepth))
        else $error("order position out of range");

endmodule

`default_nettype wire

// ===== design/adc_priority_sequencer_filter_top.sv =====
//------------------------------------------------------------------------------
// adc_priority_sequencer_filter_top: ADC conversion sequencer with averaging
// Joins the order sequencer, the request queue and the window filter.
//------------------------------------------------------------------------------
// Usage:
// A request is taken when start is high and busy is low. func 0 carries a
// conversion result, func 1 a priority request for request_channel, func 2 a
// restore of the plain order. Each request yields one result, shown for one
// cycle with o_valid high: the config word for the next channel, request_ok
// and, for stored samples, the channel and its 16-sample window average.
// A conversion that stores a sample passes the push and result states, then
// waits while the filter reads the old sample from the sample memory and
// writes the new one; busy stays high until the filter is done and the result
// is shown. Requests that store no sample show their result without waiting
// for the filter. A conversion that ends a pass with a swap pending also
// copies the pending order into the current one, which can hide the sample
// update. A priority request that is taken walks the channels to rebuild the
// pending order before its result. After reset busy stays high while the
// sample memory is cleared. Configuration writes are taken through
// i_cfg_valid/o_cfg_ready while the block is idle and start is low. The
// receiver cannot stall the result.
//------------------------------------------------------------------------------
`default_nettype none

module adc_priority_sequencer_filter_top
    import adcps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_sample,
    input  wire logic [2:0]  i_request_channel,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    output logic             o_valid,
    output logic [15:0]      o_cmd_word,
    output logic             o_avg_valid,
    output logic [2:0]       o_avg_channel,
    output logic [15:0]      o_avg_value,
    output logic             o_request_ok
);

    logic       w_hold, w_q_full, w_q_valid, w_push, w_f_ready, w_clear, w_done;
    logic       w_expect, w_res, w_remap, w_ok;
    logic [3:0] w_next;
    t_store_req w_push_data, w_q_data;
    logic [ChW-1:0] w_chan;
    logic [15:0]    w_avg;
    logic       r_wait, r_ok;
    logic       r_have;
    logic [3:0] r_next;
    logic       r_remap;
    logic       w_emit;

    // A result with an average waits in the top level until the filter is done.
    assign w_hold      = w_clear || r_wait;
    assign o_cfg_ready = !busy && !start;
    // The filter may finish during the order copy, before the result state.
    assign w_emit      = r_wait && (w_done || r_have);

    adcps_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_func            (i_func),
        .i_sample          (i_sample),
        .i_request_channel (i_request_channel),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_q_full          (w_q_full),
        .i_hold            (w_hold),
        .o_busy            (busy),
        .o_push            (w_push),
        .o_push_data       (w_push_data),
        .o_expect_avg      (w_expect),
        .o_res             (w_res),
        .o_next_select     (w_next),
        .o_remap           (w_remap),
        .o_request_ok      (w_ok)
    );

    adcps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_f_ready),
        .o_data  (w_q_data)
    );

    adcps_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (w_q_valid),
        .i_req        (w_q_data),
        .o_req_ready  (w_f_ready),
        .o_clear_busy (w_clear),
        .o_done       (w_done),
        .o_chan       (w_chan),
        .o_avg        (w_avg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait      <= 1'b0;
            r_have      <= 1'b0;
            o_valid     <= 1'b0;
            o_avg_valid <= 1'b0;
        end else begin
            o_valid     <= 1'b0;
            o_avg_valid <= 1'b0;
            if (w_res && w_expect) begin
                r_wait <= 1'b1;
            end else if (w_res) begin
                o_valid <= 1'b1;
            end
            if (w_done && !r_wait) begin
                r_have <= 1'b1;
            end
            if (w_emit) begin
                r_wait      <= 1'b0;
                r_have      <= 1'b0;
                o_valid     <= 1'b1;
                o_avg_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res) begin
            r_next  <= w_next;
            r_remap <= w_remap;
            r_ok    <= w_ok;
        end
        if (w_res && !w_expect) begin
            o_cmd_word    <= select_word(w_next, w_remap);
            o_request_ok  <= w_ok;
            o_avg_channel <= '0;
            o_avg_value   <= '0;
        end
        if (w_emit) begin
            o_cmd_word    <= select_word(r_next, r_remap);
            o_request_ok  <= r_ok;
            o_avg_channel <= w_chan;
            o_avg_value   <= w_avg;
        end
    end

    a_avg_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_avg_valid |-> o_valid)
        else $error("average strobe without result");
    a_busy_while_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |-> busy)
        else $error("idle while result pending");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result held longer than one cycle");

endmodule

`default_nettype wire
